### hdl/bptc_pkg.sv
// shared types and constants for the barometer compensation pipeline
// no dependencies; imported by every module of the block except bptc_checks
`timescale 1ns / 1ps

package bptc_pkg;

    localparam int DIV_W = 32;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_AC_SIGNED   = 3'd0,
        REG_AC_UNSIGNED = 3'd1,
        REG_B_TERMS     = 3'd2,
        REG_MC_MD       = 3'd3,
        REG_OVERSAMPLE  = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic signed [15:0] ac1;
        logic signed [15:0] ac2;
        logic signed [15:0] ac3;
        logic        [15:0] ac4;
        logic        [15:0] ac5;
        logic        [15:0] ac6;
        logic signed [15:0] b1;
        logic signed [15:0] b2;
        logic signed [15:0] mc;
        logic signed [15:0] md;
        logic        [1:0]  oss;
    } cal_t;

    // sideband through the temperature divider
    typedef struct packed {
        logic signed [31:0] x1;
        logic        [18:0] up;
        logic               fault;
        logic               neg;
    } fa_side_t;

    // sideband through the pressure divider
    typedef struct packed {
        logic signed [15:0] t;
        logic               fault;
        logic               dbl;
    } fb_side_t;

    localparam logic signed [31:0] B6_OFS     = 32'sd4000;
    localparam logic signed [31:0] T_ROUND    = 32'sd8;
    localparam logic signed [31:0] T_MAX      = 32'sd32767;
    localparam logic signed [31:0] T_MIN      = -32'sd32768;
    localparam logic        [31:0] B4_OFS     = 32'd32768;
    localparam logic        [15:0] B7_BASE    = 16'd50000;
    localparam logic signed [31:0] K_SQ       = 32'sd3038;
    localparam logic signed [31:0] K_LIN      = -32'sd7357;
    localparam logic signed [31:0] K_OFS      = 32'sd3791;
    localparam logic signed [31:0] P_MAX      = 32'sd1048575;

endpackage

### hdl/bptc_div.sv
// pipelined restoring divider, unsigned, one quotient bit per stage
// depends on bptc_pkg; carries an opaque sideband alongside the operands
`timescale 1ns / 1ps

module bptc_div #(
    parameter int SIDE_W = 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [bptc_pkg::DIV_W-1:0]     num,
    input  logic [bptc_pkg::DIV_W-1:0]     den,
    input  logic [SIDE_W-1:0]              side_in,
    output logic                           out_valid,
    output logic [bptc_pkg::DIV_W-1:0]     quo,
    output logic [SIDE_W-1:0]              side_out
);
    import bptc_pkg::*;

    localparam int N = DIV_W;

    logic [N-1:0]      valid_reg;
    logic [N-1:0]      rem_reg  [N];
    logic [N-1:0]      num_reg  [N];
    logic [N-1:0]      den_reg  [N];
    logic [SIDE_W-1:0] side_reg [N];

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_stage
            logic          src_v;
            logic [N-1:0]  src_r;
            logic [N-1:0]  src_n;
            logic [N-1:0]  src_d;
            logic [SIDE_W-1:0] src_s;
            logic [N:0]    shifted;
            logic [N:0]    trial;
            logic          ge;

            if (k == 0)
            begin : g_first
                assign src_v = in_valid;
                assign src_r = '0;
                assign src_n = num;
                assign src_d = den;
                assign src_s = side_in;
            end
            else
            begin : g_rest
                assign src_v = valid_reg[k-1];
                assign src_r = rem_reg[k-1];
                assign src_n = num_reg[k-1];
                assign src_d = den_reg[k-1];
                assign src_s = side_reg[k-1];
            end

            assign shifted = {src_r, src_n[N-1]};
            assign trial   = shifted - {1'b0, src_d};
            assign ge      = ~trial[N];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[k] <= 1'b0;
                else if (en)
                    valid_reg[k] <= src_v;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= ge ? trial[N-1:0] : shifted[N-1:0];
                    num_reg[k]  <= {src_n[N-2:0], ge};
                    den_reg[k]  <= src_d;
                    side_reg[k] <= src_s;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[N-1];
    assign quo       = num_reg[N-1];
    assign side_out  = side_reg[N-1];

endmodule

### hdl/bptc_front.sv
// temperature front end: x1 term, then divider operands for the x2 term
// depends on bptc_pkg; feeds the first bptc_div
`timescale 1ns / 1ps

module bptc_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  bptc_pkg::cal_t               cal,
    input  logic                         in_valid,
    input  logic [15:0]                  raw_temp,
    input  logic [18:0]                  raw_press,
    output logic                         out_valid,
    output logic [bptc_pkg::DIV_W-1:0]   num,
    output logic [bptc_pkg::DIV_W-1:0]   den,
    output bptc_pkg::fa_side_t           side
);
    import bptc_pkg::*;

    logic               s1_valid_reg;
    logic signed [31:0] s1_x1_reg;
    logic        [18:0] s1_up_reg;
    logic               s2_valid_reg;
    logic [31:0]        s2_num_reg;
    logic [31:0]        s2_den_reg;
    fa_side_t           s2_side_reg;

    logic signed [16:0] dt;
    logic signed [33:0] prod;
    logic signed [31:0] s1_x1_next;
    logic signed [31:0] den_s;
    logic signed [31:0] num_s;
    logic [31:0]        s2_num_next;
    logic [31:0]        s2_den_next;
    fa_side_t           s2_side_next;

    always_comb
    begin
        dt         = $signed({1'b0, raw_temp}) - $signed({1'b0, cal.ac6});
        prod       = dt * $signed({1'b0, cal.ac5});
        s1_x1_next = $signed(prod[31:0]) >>> 15;

        den_s = s1_x1_reg + 32'(cal.md);
        num_s = {{5{cal.mc[15]}}, cal.mc, 11'b0};
        s2_num_next = num_s[31] ? 32'(-num_s) : num_s;
        s2_den_next = den_s[31] ? 32'(-den_s) : den_s;
        s2_side_next.x1    = s1_x1_reg;
        s2_side_next.up    = s1_up_reg;
        s2_side_next.fault = (den_s == 32'sd0);
        s2_side_next.neg   = num_s[31] ^ den_s[31];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_x1_reg   <= s1_x1_next;
            s1_up_reg   <= raw_press;
            s2_num_reg  <= s2_num_next;
            s2_den_reg  <= s2_den_next;
            s2_side_reg <= s2_side_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign num       = s2_num_reg;
    assign den       = s2_den_reg;
    assign side      = s2_side_reg;

endmodule

### hdl/bptc_mid.sv
// middle section: temperature result, b3/b4/b7 terms, pressure divider operands
// depends on bptc_pkg; sits between the two bptc_div instances
`timescale 1ns / 1ps

module bptc_mid (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  bptc_pkg::cal_t               cal,
    input  logic                         in_valid,
    input  logic [bptc_pkg::DIV_W-1:0]   quo,
    input  bptc_pkg::fa_side_t           side_in,
    output logic                         out_valid,
    output logic [bptc_pkg::DIV_W-1:0]   num,
    output logic [bptc_pkg::DIV_W-1:0]   den,
    output bptc_pkg::fb_side_t           side_out
);
    import bptc_pkg::*;

    logic [5:0] valid_reg;

    // stage 1
    logic signed [15:0] m1_t_reg;
    logic signed [31:0] m1_b6_reg;
    logic        [18:0] m1_up_reg;
    logic               m1_fault_reg;
    // stage 2
    logic signed [15:0] m2_t_reg;
    logic signed [31:0] m2_sq_reg;
    logic signed [31:0] m2_a2_reg;
    logic signed [31:0] m2_a3_reg;
    logic        [18:0] m2_up_reg;
    logic               m2_fault_reg;
    // stage 3
    logic signed [15:0] m3_t_reg;
    logic signed [31:0] m3_bb2_reg;
    logic signed [31:0] m3_bb1_reg;
    logic signed [31:0] m3_a2_reg;
    logic signed [31:0] m3_a3_reg;
    logic        [18:0] m3_up_reg;
    logic               m3_fault_reg;
    // stage 4
    logic signed [15:0] m4_t_reg;
    logic signed [31:0] m4_b3_reg;
    logic signed [31:0] m4_x3_reg;
    logic        [18:0] m4_up_reg;
    logic               m4_fault_reg;
    // stage 5
    logic signed [15:0] m5_t_reg;
    logic        [31:0] m5_b4_reg;
    logic        [31:0] m5_b7_reg;
    logic               m5_fault_reg;
    // stage 6
    logic [31:0]        m6_num_reg;
    logic [31:0]        m6_den_reg;
    fb_side_t           m6_side_reg;

    logic signed [31:0] x2;
    logic signed [31:0] b5;
    logic signed [31:0] tw;
    logic signed [15:0] m1_t_next;
    logic signed [31:0] m1_b6_next;
    logic signed [63:0] sq_full;
    logic signed [47:0] a2_full;
    logic signed [47:0] a3_full;
    logic signed [47:0] bb2_full;
    logic signed [47:0] bb1_full;
    logic signed [31:0] x3a;
    logic signed [31:0] v0;
    logic signed [31:0] v1;
    logic signed [31:0] v2;
    logic signed [31:0] m4_b3_next;
    logic signed [31:0] m4_x3_next;
    logic        [31:0] b4_arg;
    logic        [47:0] b4_full;
    logic        [31:0] diff;
    logic        [15:0] scale;
    logic        [47:0] b7_full;
    fb_side_t           m6_side_next;

    always_comb
    begin
        x2 = side_in.neg ? 32'(-$signed(quo)) : $signed(quo);
        b5 = side_in.x1 + x2;
        tw = (b5 + T_ROUND) >>> 4;
        if (tw > T_MAX)
            m1_t_next = T_MAX[15:0];
        else if (tw < T_MIN)
            m1_t_next = T_MIN[15:0];
        else
            m1_t_next = tw[15:0];
        m1_b6_next = b5 - B6_OFS;

        sq_full = m1_b6_reg * m1_b6_reg;
        a2_full = cal.ac2 * m1_b6_reg;
        a3_full = cal.ac3 * m1_b6_reg;

        bb2_full = cal.b2 * m2_sq_reg;
        bb1_full = cal.b1 * m2_sq_reg;

        x3a = (m3_bb2_reg >>> 11) + (m3_a2_reg >>> 11);
        v0  = 32'(cal.ac1) * 32'sd4 + x3a;
        v1  = v0 <<< cal.oss;
        v2  = v1 + 32'sd2;
        // divide by four, rounding toward zero
        m4_b3_next = (v2 + (v2[31] ? 32'sd3 : 32'sd0)) >>> 2;
        m4_x3_next = ((m3_a3_reg >>> 13) + (m3_bb1_reg >>> 16) + 32'sd2) >>> 2;

        b4_arg  = 32'(m4_x3_reg) + B4_OFS;
        b4_full = {32'b0, cal.ac4} * {16'b0, b4_arg};
        diff    = {13'b0, m4_up_reg} - 32'(m4_b3_reg);
        scale   = B7_BASE >> cal.oss;
        b7_full = {16'b0, diff} * {32'b0, scale};

        m6_side_next.t     = m5_t_reg;
        m6_side_next.fault = m5_fault_reg | (m5_b4_reg == 32'd0);
        m6_side_next.dbl   = m5_b7_reg[31];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[4:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_t_reg     <= m1_t_next;
            m1_b6_reg    <= m1_b6_next;
            m1_up_reg    <= side_in.up;
            m1_fault_reg <= side_in.fault;

            m2_t_reg     <= m1_t_reg;
            m2_sq_reg    <= $signed(sq_full[31:0]) >>> 12;
            m2_a2_reg    <= a2_full[31:0];
            m2_a3_reg    <= a3_full[31:0];
            m2_up_reg    <= m1_up_reg;
            m2_fault_reg <= m1_fault_reg;

            m3_t_reg     <= m2_t_reg;
            m3_bb2_reg   <= bb2_full[31:0];
            m3_bb1_reg   <= bb1_full[31:0];
            m3_a2_reg    <= m2_a2_reg;
            m3_a3_reg    <= m2_a3_reg;
            m3_up_reg    <= m2_up_reg;
            m3_fault_reg <= m2_fault_reg;

            m4_t_reg     <= m3_t_reg;
            m4_b3_reg    <= m4_b3_next;
            m4_x3_reg    <= m4_x3_next;
            m4_up_reg    <= m3_up_reg;
            m4_fault_reg <= m3_fault_reg;

            m5_t_reg     <= m4_t_reg;
            m5_b4_reg    <= {15'b0, b4_full[31:15]};
            m5_b7_reg    <= b7_full[31:0];
            m5_fault_reg <= m4_fault_reg;

            // large b7 divides first and doubles after
            m6_num_reg  <= m5_b7_reg[31] ? m5_b7_reg : {m5_b7_reg[30:0], 1'b0};
            m6_den_reg  <= m5_b4_reg;
            m6_side_reg <= m6_side_next;
        end
    end

    assign out_valid = valid_reg[5];
    assign num       = m6_num_reg;
    assign den       = m6_den_reg;
    assign side_out  = m6_side_reg;

endmodule

### hdl/bptc_back.sv
// pressure back end: second-order correction, saturation, output register
// depends on bptc_pkg; follows the second bptc_div
`timescale 1ns / 1ps

module bptc_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [bptc_pkg::DIV_W-1:0]   quo,
    input  bptc_pkg::fb_side_t           side_in,
    output logic                         out_valid,
    output logic signed [15:0]           temp_tenths,
    output logic [19:0]                  press_pa,
    output logic                         div_fault
);
    import bptc_pkg::*;

    logic [2:0] valid_reg;

    logic signed [31:0] k1_p_reg;
    logic signed [31:0] k1_x1_reg;
    logic signed [31:0] k1_x2_reg;
    fb_side_t           k1_side_reg;
    logic signed [31:0] k2_p_reg;
    logic signed [31:0] k2_x1_reg;
    logic signed [31:0] k2_x2_reg;
    fb_side_t           k2_side_reg;
    logic signed [15:0] temp_reg;
    logic        [19:0] press_reg;
    logic               fault_reg;

    logic signed [31:0] p;
    logic signed [31:0] ps;
    logic signed [63:0] x1_full;
    logic signed [63:0] x2_full;
    logic signed [63:0] x1k_full;
    logic signed [31:0] corr;
    logic signed [31:0] p2;
    logic signed [15:0] temp_next;
    logic        [19:0] press_next;

    always_comb
    begin
        p        = side_in.dbl ? $signed({quo[30:0], 1'b0}) : $signed(quo);
        ps       = p >>> 8;
        x1_full  = ps * ps;
        x2_full  = K_LIN * p;
        x1k_full = k1_x1_reg * K_SQ;

        corr = (k2_x1_reg + k2_x2_reg + K_OFS) >>> 4;
        p2   = k2_p_reg + corr;
        if (k2_side_reg.fault)
        begin
            temp_next  = '0;
            press_next = '0;
        end
        else
        begin
            temp_next = k2_side_reg.t;
            if (p2[31])
                press_next = '0;
            else if (p2 > P_MAX)
                press_next = P_MAX[19:0];
            else
                press_next = p2[19:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k1_p_reg    <= p;
            k1_x1_reg   <= x1_full[31:0];
            k1_x2_reg   <= x2_full[31:0];
            k1_side_reg <= side_in;

            k2_p_reg    <= k1_p_reg;
            k2_x1_reg   <= $signed(x1k_full[31:0]) >>> 16;
            k2_x2_reg   <= k1_x2_reg >>> 16;
            k2_side_reg <= k1_side_reg;

            temp_reg  <= temp_next;
            press_reg <= press_next;
            fault_reg <= k2_side_reg.fault;
        end
    end

    assign out_valid   = valid_reg[2];
    assign temp_tenths = temp_reg;
    assign press_pa    = press_reg;
    assign div_fault   = fault_reg;

endmodule

### hdl/baro_temp_pressure_compensation.sv
// Barometer compensation: one raw temperature and pressure pair in, one
// result word out (temperature in 0.1 degC, pressure in Pa, divide fault).
// Fully pipelined: a new word is taken every cycle while the pipe advances,
// and each word passes 2 front stages, two 32-stage dividers at one quotient bit
// per stage, 6 middle stages and 3 back stages including the output register.
// The whole pipe advances when the output register is empty or being
// taken, so in_ready follows out_ready combinationally. Calibration
// registers are written through cfg and always accepted; write them only
// while the pipe is empty. Depends on bptc_pkg and all bptc_* modules.
`timescale 1ns / 1ps

module baro_temp_pressure_compensation (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [47:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [15:0]        raw_temp,
    input  logic [18:0]        raw_press,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] temp_tenths,
    output logic [19:0]        press_pa,
    output logic               div_fault
);
    import bptc_pkg::*;

    logic [47:0] ac_s_reg;
    logic [47:0] ac_u_reg;
    logic [31:0] bt_reg;
    logic [31:0] mcmd_reg;
    logic [1:0]  oss_reg;
    cal_t        cal;
    logic        adv;

    logic                 fa_in_valid;
    logic [DIV_W-1:0]     fa_num;
    logic [DIV_W-1:0]     fa_den;
    fa_side_t             fa_side_in;
    logic                 fa_out_valid;
    logic [DIV_W-1:0]     fa_quo;
    fa_side_t             fa_side_out;

    logic                 fb_in_valid;
    logic [DIV_W-1:0]     fb_num;
    logic [DIV_W-1:0]     fb_den;
    fb_side_t             fb_side_in;
    logic                 fb_out_valid;
    logic [DIV_W-1:0]     fb_quo;
    fb_side_t             fb_side_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ac_s_reg <= '0;
            ac_u_reg <= '0;
            bt_reg   <= '0;
            mcmd_reg <= '0;
            oss_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_AC_SIGNED:   ac_s_reg <= cfg_data;
                REG_AC_UNSIGNED: ac_u_reg <= cfg_data;
                REG_B_TERMS:     bt_reg   <= cfg_data[31:0];
                REG_MC_MD:       mcmd_reg <= cfg_data[31:0];
                REG_OVERSAMPLE:  oss_reg  <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cal.ac1 = $signed(ac_s_reg[15:0]);
        cal.ac2 = $signed(ac_s_reg[31:16]);
        cal.ac3 = $signed(ac_s_reg[47:32]);
        cal.ac4 = ac_u_reg[15:0];
        cal.ac5 = ac_u_reg[31:16];
        cal.ac6 = ac_u_reg[47:32];
        cal.b1  = $signed(bt_reg[15:0]);
        cal.b2  = $signed(bt_reg[31:16]);
        cal.mc  = $signed(mcmd_reg[15:0]);
        cal.md  = $signed(mcmd_reg[31:16]);
        cal.oss = oss_reg;
    end

    // the whole pipe moves as one when the output word is free
    assign adv      = ~out_valid | out_ready;
    assign in_ready = adv;

    bptc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .cal       (cal),
        .in_valid  (in_valid),
        .raw_temp  (raw_temp),
        .raw_press (raw_press),
        .out_valid (fa_in_valid),
        .num       (fa_num),
        .den       (fa_den),
        .side      (fa_side_in)
    );

    bptc_div #(.SIDE_W($bits(fa_side_t))) u_div_temp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (fa_in_valid),
        .num       (fa_num),
        .den       (fa_den),
        .side_in   (fa_side_in),
        .out_valid (fa_out_valid),
        .quo       (fa_quo),
        .side_out  (fa_side_out)
    );

    bptc_mid u_mid (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .cal       (cal),
        .in_valid  (fa_out_valid),
        .quo       (fa_quo),
        .side_in   (fa_side_out),
        .out_valid (fb_in_valid),
        .num       (fb_num),
        .den       (fb_den),
        .side_out  (fb_side_in)
    );

    bptc_div #(.SIDE_W($bits(fb_side_t))) u_div_press (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (fb_in_valid),
        .num       (fb_num),
        .den       (fb_den),
        .side_in   (fb_side_in),
        .out_valid (fb_out_valid),
        .quo       (fb_quo),
        .side_out  (fb_side_out)
    );

    bptc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (adv),
        .in_valid    (fb_out_valid),
        .quo         (fb_quo),
        .side_in     (fb_side_out),
        .out_valid   (out_valid),
        .temp_tenths (temp_tenths),
        .press_pa    (press_pa),
        .div_fault   (div_fault)
    );

endmodule

### hdl/bptc_checks.sv
// port-level checks for the compensation block, bound to the top level
// depends only on the top level's ports
`timescale 1ns / 1ps

module bptc_checks (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [15:0] temp_tenths,
    input  logic [19:0]        press_pa,
    input  logic               div_fault
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(temp_tenths)
            && $stable(press_pa) && $stable(div_fault))
        else $error("output word changed while stalled");

    // a fault word carries zero values
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && div_fault |-> temp_tenths == 16'sd0 && press_pa == 20'd0)
        else $error("fault word with nonzero values");

    // input side is open whenever the output word can move
    a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow the output side");

    // configuration writes are never stalled
    a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind baro_temp_pressure_compensation bptc_checks u_checks (.*);

### tb/bptc_checker.sv
// checker for the barometer compensation block: keeps its own calibration copy,
// predicts each result word and compares it with what the block returns
// depends on bptc_pkg
`timescale 1ns / 1ps

module bptc_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [47:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [15:0]        raw_temp,
    input  logic [18:0]        raw_press,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [15:0] temp_tenths,
    input  logic [19:0]        press_pa,
    input  logic               div_fault,
    output int                 errors,
    output int                 pending
);
    import bptc_pkg::*;

    typedef struct packed {
        logic signed [15:0] t;
        logic        [19:0] p;
        logic               fault;
    } reading_t;

    cal_t     cal;
    reading_t readings_due[$];

    function automatic longint w32(longint v);
        return longint'($signed(v[31:0]));
    endfunction

    function automatic reading_t compensate(logic [15:0] ut_r, logic [18:0] up_r);
        longint ut, up, ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        longint x1, x2, x3, b3, b5, b6, sq, den, t, p;
        logic [31:0] u32, b4, b7, pu;
        logic [63:0] prod;
        reading_t r;
        r = '0;
        ut = longint'(ut_r);
        up = longint'(up_r);
        ac1 = longint'(cal.ac1);
        ac2 = longint'(cal.ac2);
        ac3 = longint'(cal.ac3);
        ac4 = longint'(cal.ac4);
        ac5 = longint'(cal.ac5);
        ac6 = longint'(cal.ac6);
        b1 = longint'(cal.b1);
        b2 = longint'(cal.b2);
        mc = longint'(cal.mc);
        md = longint'(cal.md);

        x1 = w32((ut - ac6) * ac5) >>> 15;
        den = w32(x1 + md);
        if (den == 0)
        begin
            r.fault = 1'b1;
            return r;
        end
        x2 = w32((mc * 2048) / den);
        b5 = w32(x1 + x2);
        t = w32(b5 + 8) >>> 4;

        b6 = w32(b5 - 4000);
        sq = w32(b6 * b6) >>> 12;
        x1 = w32(b2 * sq) >>> 11;
        x2 = w32(ac2 * b6) >>> 11;
        x3 = w32(x1 + x2);
        b3 = w32(w32(w32(ac1 * 4 + x3) * (longint'(1) << cal.oss)) + 2) / 4;
        x1 = w32(ac3 * b6) >>> 13;
        x2 = w32(b1 * sq) >>> 16;
        x3 = w32(w32(x1 + x2) + 2) >>> 2;
        u32 = 32'(x3 + 32768);
        prod = 64'(ac4) * 64'(u32);
        b4 = prod[31:0] >> 15;
        if (b4 == 0)
        begin
            r.fault = 1'b1;
            return r;
        end
        u32 = 32'(up - b3);
        prod = 64'(u32) * 64'(32'd50000 >> cal.oss);
        b7 = prod[31:0];
        // b7 is unsigned: the doubling must not overflow
        if (b7 < 32'h8000_0000)
            pu = (b7 * 32'd2) / b4;
        else
            pu = (b7 / b4) * 32'd2;
        p = w32(longint'(pu));
        x1 = w32((p >>> 8) * (p >>> 8));
        x1 = w32(x1 * 3038) >>> 16;
        x2 = w32(-7357 * p) >>> 16;
        p = w32(p + (w32(x1 + x2 + 3791) >>> 4));

        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        if (p < 0) p = 0;
        if (p > 1048575) p = 1048575;
        r.t = t[15:0];
        r.p = p[19:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        if (!rst_n)
        begin
            cal = '0;
            readings_due.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_AC_SIGNED:   {cal.ac3, cal.ac2, cal.ac1} = cfg_data;
                    REG_AC_UNSIGNED: {cal.ac6, cal.ac5, cal.ac4} = cfg_data;
                    REG_B_TERMS:     {cal.b2, cal.b1} = cfg_data[31:0];
                    REG_MC_MD:       {cal.md, cal.mc} = cfg_data[31:0];
                    REG_OVERSAMPLE:  cal.oss = cfg_data[1:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (readings_due.size() == 0)
                begin
                    $error("unexpected result word t=%0d p=%0d f=%0b",
                           temp_tenths, press_pa, div_fault);
                    errors++;
                end
                else
                begin
                    want = readings_due.pop_front();
                    if (temp_tenths !== want.t)
                    begin
                        $error("temp_tenths expected %0d actual %0d", want.t, temp_tenths);
                        errors++;
                    end
                    if (press_pa !== want.p)
                    begin
                        $error("press_pa expected %0d actual %0d", want.p, press_pa);
                        errors++;
                    end
                    if (div_fault !== want.fault)
                    begin
                        $error("div_fault expected %0b actual %0b", want.fault, div_fault);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
                readings_due.push_back(compensate(raw_temp, raw_press));
            pending = readings_due.size();
        end
    end

endmodule

### tb/testbench.sv
// top of the barometer compensation testbench: clock, reset, calibration
// phases and sample stimulus; depends on bptc_pkg, bptc_checker and the block
`timescale 1ns / 1ps

module testbench;
    import bptc_pkg::*;

    localparam logic [2:0] REG_SPARE = 3'd7;
    localparam int         DRAIN     = 100;
    localparam int         LIMIT     = 400000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [47:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [15:0]        raw_temp = '0;
    logic [18:0]        raw_press = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [15:0] temp_tenths;
    logic [19:0]        press_pa;
    logic               div_fault;
    logic               quiet = 1'b0;
    int                 errors;
    int                 pending;
    int                 cycles = 0;

    baro_temp_pressure_compensation i_dut (.*);

    bptc_checker i_checker (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver stalls in bursts
    always
    begin
        @(posedge clk);
        if (rst_n && !quiet && $urandom_range(0, 3) == 0)
        begin
            out_ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        out_ready <= 1'b1;
    end

    task automatic write_reg(logic [2:0] idx, logic [47:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        while (!cfg_ready) @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_cal(logic [47:0] acs, logic [47:0] acu, logic [31:0] bt,
                            logic [31:0] mm, logic [1:0] oss);
        write_reg(REG_AC_SIGNED, acs);
        write_reg(REG_AC_UNSIGNED, acu);
        write_reg(REG_B_TERMS, {16'h0, bt});
        write_reg(REG_MC_MD, {16'h0, mm});
        write_reg(REG_OVERSAMPLE, {46'h0, oss});
    endtask

    // valid stays high across back-to-back words
    task automatic send_sample(logic [15:0] ut, logic [18:0] up);
        in_valid <= 1'b1;
        raw_temp <= ut;
        raw_press <= up;
        @(negedge clk);
        while (!in_ready) @(negedge clk);
        @(posedge clk);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic random_samples(int n, bit typical, logic [1:0] oss);
        for (int k = 0; k < n; k++)
        begin
            if (typical && $urandom_range(0, 4) != 0)
                send_sample(16'($urandom_range(20000, 36000)),
                            19'($urandom_range(18000, 45000) << oss));
            else
                send_sample(16'($urandom), 19'($urandom));
        end
    endtask

    // typical factory calibration
    localparam logic [47:0] ACS_TYP = {16'hC7D1, 16'hFFB8, 16'h0198};
    localparam logic [47:0] ACU_TYP = {16'd23153, 16'd32757, 16'd32741};
    localparam logic [31:0] BT_TYP  = {16'd4, 16'd6190};
    localparam logic [31:0] MM_TYP  = {16'd2868, 16'hDDF9};

    initial
    begin
        logic [1:0] oss;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset calibration: every word hits the zero divisor
        send_sample(16'd0, 19'd0);
        send_sample(16'hFFFF, 19'h7FFFF);
        drain();

        load_cal(ACS_TYP, ACU_TYP, BT_TYP, MM_TYP, 2'd0);
        write_reg(REG_SPARE, 48'hFFFF_FFFF_FFFF);
        send_sample(16'd27898, 19'd23843);
        send_sample(16'd0, 19'd0);
        send_sample(16'hFFFF, 19'h7FFFF);
        send_sample(16'd0, 19'h7FFFF);
        send_sample(16'hFFFF, 19'd0);
        send_sample(16'h5555, 19'h2AAAA);
        send_sample(16'hAAAA, 19'h55555);
        send_sample(16'd23153, 19'd1);
        drain();

        // zero divisor on the temperature path: ac5 zero and md zero
        load_cal(ACS_TYP, {16'd23153, 16'd0, 16'd32741}, BT_TYP, {16'd0, 16'hDDF9}, 2'd1);
        send_sample(16'd27898, 19'd47686);
        send_sample(16'hFFFF, 19'h7FFFF);
        drain();

        // zero divisor on the pressure path: ac4 zero
        load_cal(ACS_TYP, {16'd23153, 16'd32757, 16'd0}, BT_TYP, MM_TYP, 2'd2);
        send_sample(16'd27898, 19'd95372);
        send_sample(16'd0, 19'd0);
        drain();

        // extremes of every coefficient
        load_cal(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3);
        send_sample(16'd0, 19'd0);
        send_sample(16'hFFFF, 19'h7FFFF);
        send_sample(16'h8000, 19'h40000);
        drain();
        load_cal({3{16'h8000}}, {3{16'h8000}}, {2{16'h7FFF}}, {16'h7FFF, 16'h8000}, 2'd0);
        send_sample(16'd0, 19'h7FFFF);
        send_sample(16'hFFFF, 19'd0);
        random_samples(20, 1'b0, 2'd0);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            oss = 2'(ph);
            load_cal(ACS_TYP, ACU_TYP, BT_TYP, MM_TYP, oss);
            random_samples(120, 1'b1, oss);
            drain();
        end

        // perturbed calibrations reach wraps and saturation
        for (int ph = 0; ph < 4; ph++)
        begin
            oss = 2'($urandom);
            if (ph % 2 == 0)
                load_cal(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                         $urandom, $urandom, oss);
            else
                load_cal(ACS_TYP ^ 48'($urandom & 32'h0F0F_0F0F),
                         ACU_TYP ^ 48'($urandom_range(0, 4095)),
                         BT_TYP ^ ($urandom & 32'h00FF_00FF),
                         MM_TYP ^ ($urandom & 32'h003F_03FF), oss);
            random_samples(60, 1'b1, oss);
            drain();
        end

        load_cal(ACS_TYP, ACU_TYP, BT_TYP, MM_TYP, 2'd3);
        quiet <= 1'b1;
        random_samples(120, 1'b1, 2'd3);
        drain();

        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
